[design/mrr_pkg.sv]
// shared constants, types and helpers for the masked row reduction unit
`default_nettype none

package mrr_pkg;

  // fixed point format and row limits
  localparam int FRAC_BITS   = 16;
  localparam int MAX_ROW_LEN = 65536;
  localparam int COUNT_CAP   = (MAX_ROW_LEN < 131071) ? MAX_ROW_LEN : 131071;

  // field widths
  localparam int VALUE_W     = 32;
  localparam int RESULT_W    = 64;
  localparam int COUNT_W     = 17;
  localparam int MODE_W      = 3;
  localparam int OUT_TDATA_W = 88;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // saturation limits and the value 1.0
  localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};
  localparam logic [RESULT_W-1:0] ONE_Q   = 64'd1 << FRAC_BITS;

  // reduction modes as written to the mode register
  typedef enum logic [MODE_W-1:0] {
    MODE_SUM   = 3'd0,
    MODE_PROD  = 3'd1,
    MODE_MEAN  = 3'd2,
    MODE_MAX   = 3'd3,
    MODE_MIN   = 3'd4,
    MODE_COUNT = 3'd5
  } mode_t;

  // work the back end does for one queued element
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_SUM   = 3'd1,
    OP_PROD  = 3'd2,
    OP_MAX   = 3'd3,
    OP_MIN   = 3'd4,
    OP_COUNT = 3'd5
  } op_t;

  // one classified element in the queue
  typedef struct packed {
    op_t                       op;
    logic                      last;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic has_data;
    logic has_room;
  } q_stat_t;

  // configuration control from the top level
  typedef struct packed {
    logic  clear;
    mode_t mode;
  } cfg_ctl_t;

  // accumulator value at the start of a row
  function automatic logic [RESULT_W-1:0] start_value(input mode_t m);
    return (m == MODE_PROD) ? ONE_Q : '0;
  endfunction

endpackage

`default_nettype wire

[design/mrr_front.sv]
// front end: accepts elements, classifies them and pushes them to the queue
`default_nettype none

module mrr_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mrr_pkg::mode_t                  mode_i,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mrr_pkg::VALUE_W-1:0]     in_tdata,   // sample_value
  input  wire logic                            in_tuser,   // is_masked
  input  wire logic                            in_tlast,   // row_last
  input  wire mrr_pkg::q_stat_t                q_stat_i,
  output logic                                 push_o,
  output mrr_pkg::entry_t                      entry_o
);
  import mrr_pkg::*;

  logic   slot_valid_r, slot_valid_nxt;
  entry_t slot_r, slot_nxt;
  logic   in_fire;
  logic   keep;
  op_t    op_cls;

  // slot empties into the queue whenever there is room
  assign push_o    = slot_valid_r && q_stat_i.has_room;
  assign in_tready = !slot_valid_r || q_stat_i.has_room;
  assign in_fire   = in_tvalid && in_tready;
  assign entry_o   = slot_r;

  // masked elements that do not close a row cause nothing downstream
  assign keep = !in_tuser || in_tlast;

  // map the element onto the operation of the current mode
  always_comb begin
    op_cls = OP_COUNT;
    if (in_tuser) begin
      op_cls = OP_NONE;
    end else begin
      case (mode_i)
        MODE_SUM, MODE_MEAN: op_cls = OP_SUM;
        MODE_PROD:           op_cls = OP_PROD;
        MODE_MAX:            op_cls = OP_MAX;
        MODE_MIN:            op_cls = OP_MIN;
        default:             op_cls = OP_COUNT;
      endcase
    end
  end

  // slot update
  always_comb begin
    slot_valid_nxt = slot_valid_r && !push_o;
    slot_nxt       = slot_r;
    if (in_fire && keep) begin
      slot_valid_nxt = 1'b1;
      slot_nxt.op    = op_cls;
      slot_nxt.last  = in_tlast;
      slot_nxt.value = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

`default_nettype wire

[design/mrr_queue.sv]
// short element queue between the front and back ends
`default_nettype none

module mrr_queue #(
  parameter int DEPTH = mrr_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire mrr_pkg::entry_t   entry_i,
  input  wire logic              pop_i,
  output mrr_pkg::entry_t        entry_o,
  output mrr_pkg::q_stat_t       stat_o
);
  import mrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               do_push, do_pop;

  assign stat_o.has_data = (fill_r != '0);
  assign stat_o.has_room = (fill_r != CNT_W'(DEPTH));
  assign do_push = push_i && stat_o.has_room;
  assign do_pop  = pop_i && stat_o.has_data;
  assign entry_o = slots_r[rd_ptr_r];

  // pointer and fill count update with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[design/mrr_div.sv]
// signed by unsigned radix-2 divider for the row mean, truncating toward zero
`default_nettype none

module mrr_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start_i,
  input  wire logic [mrr_pkg::RESULT_W-1:0]     dividend_i,
  input  wire logic [mrr_pkg::COUNT_W-1:0]      divisor_i,
  output logic                                  done_o,
  output logic [mrr_pkg::RESULT_W-1:0]          quotient_o
);
  import mrr_pkg::*;

  localparam int STEP_W = $clog2(RESULT_W);

  logic                  busy_r, busy_nxt;
  logic                  fin_r, fin_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  neg_r, neg_nxt;
  logic [RESULT_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W-1:0]    rem_r, rem_nxt;
  logic [COUNT_W-1:0]    dvs_r, dvs_nxt;
  logic [RESULT_W-1:0]   q_r, q_nxt;
  logic [COUNT_W:0]      shifted;
  logic [COUNT_W:0]      trial;
  logic                  ge;

  assign done_o     = done_r;
  assign quotient_o = q_r;

  // one quotient bit per cycle
  assign shifted = {rem_r, quo_r[RESULT_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = !trial[COUNT_W];

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start_i) begin
      // load the magnitude of the dividend
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend_i[RESULT_W-1];
      quo_nxt  = dividend_i[RESULT_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_nxt  = '0;
      dvs_nxt  = divisor_i;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_nxt  = {quo_r[RESULT_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(RESULT_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      // restore the sign
      q_nxt    = neg_r ? (~quo_r + 1'b1) : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    q_r    <= q_nxt;
  end

endmodule

`default_nettype wire

[design/mrr_back.sv]
// back end: runs the row reduction, closes rows and holds the result register
`default_nettype none

module mrr_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mrr_pkg::cfg_ctl_t                 cfg_i,
  input  wire mrr_pkg::mode_t                    mode_i,
  input  wire mrr_pkg::q_stat_t                  q_stat_i,
  input  wire mrr_pkg::entry_t                   entry_i,
  output logic                                   pop_o,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [mrr_pkg::OUT_TDATA_W-1:0]        out_tdata,  // row_result, unmasked_count
  output logic                                   out_tuser   // row_empty
);
  import mrr_pkg::*;

  localparam int PAD_W  = OUT_TDATA_W - RESULT_W - COUNT_W;
  localparam int HALF_W = RESULT_W / 2;
  localparam int WIDE_W = RESULT_W + VALUE_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MAG  = 9'b000000010,
    ST_MLO  = 9'b000000100,
    ST_MHI  = 9'b000001000,
    ST_MADD = 9'b000010000,
    ST_MSAT = 9'b000100000,
    ST_FIN  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RESULT_W-1:0]   acc_r, acc_nxt;
  logic [VALUE_W-1:0]    best_r, best_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic                  last_r, last_nxt;
  logic [RESULT_W-1:0]   ma_r, ma_nxt;
  logic [VALUE_W-1:0]    mb_r, mb_nxt;
  logic                  neg_r, neg_nxt;
  logic [RESULT_W-1:0]   plo_r, plo_nxt;
  logic [RESULT_W-1:0]   phi_r, phi_nxt;
  logic [WIDE_W-1:0]     wide_r, wide_nxt;
  logic [RESULT_W-1:0]   res_r, res_nxt;
  logic                  empty_r, empty_nxt;
  logic [COUNT_W-1:0]    rcnt_r, rcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]   out_res_r, out_res_nxt;
  logic [COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic [HALF_W-1:0]     mul_a;
  logic [RESULT_W-1:0]   mul_p;
  logic [RESULT_W:0]     sum_w;
  logic [RESULT_W-1:0]   sum_sat;
  logic [WIDE_W-1:0]     shifted;
  logic [RESULT_W-1:0]   prod_sat;
  logic                  row_empty;
  logic                  div_start;
  logic                  div_done;
  logic [RESULT_W-1:0]   div_quo;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_empty_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_cnt_r, out_res_r};
  assign row_empty  = (cnt_r == '0);

  // shared 32 by 32 multiplier for both halves of the accumulator
  assign mul_a = (state_r == ST_MLO) ? ma_r[HALF_W-1:0] : ma_r[RESULT_W-1:HALF_W];
  assign mul_p = RESULT_W'(mul_a) * RESULT_W'(mb_r);

  // saturating add of the incoming element
  assign sum_w = {acc_r[RESULT_W-1], acc_r}
               + {{(RESULT_W-VALUE_W+1){entry_i.value[VALUE_W-1]}}, entry_i.value};
  always_comb begin
    sum_sat = sum_w[RESULT_W-1:0];
    if (sum_w[RESULT_W] != sum_w[RESULT_W-1]) begin
      sum_sat = sum_w[RESULT_W] ? RES_MIN : RES_MAX;
    end
  end

  // rescale and saturate the product magnitude, then apply the sign
  assign shifted = wide_r >> FRAC_BITS;
  always_comb begin
    if ((|shifted[WIDE_W-1:RESULT_W]) || shifted[RESULT_W-1]) begin
      prod_sat = neg_r ? RES_MIN : RES_MAX;
    end else begin
      prod_sat = neg_r ? (~shifted[RESULT_W-1:0] + 1'b1) : shifted[RESULT_W-1:0];
    end
  end

  mrr_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (acc_r),
    .divisor_i  (cnt_r),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    neg_nxt       = neg_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    wide_nxt      = wide_r;
    res_nxt       = res_r;
    empty_nxt     = empty_r;
    rcnt_nxt      = rcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    pop_o         = 1'b0;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_stat_i.has_data) begin
          pop_o    = 1'b1;
          val_nxt  = entry_i.value;
          last_nxt = entry_i.last;
          // saturating element count
          if (entry_i.op != OP_NONE && cnt_r < COUNT_W'(COUNT_CAP)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          case (entry_i.op)
            OP_SUM: acc_nxt = sum_sat;
            OP_MAX: begin
              if (row_empty || $signed(entry_i.value) > $signed(best_r)) begin
                best_nxt = entry_i.value;
              end
            end
            OP_MIN: begin
              if (row_empty || $signed(entry_i.value) < $signed(best_r)) begin
                best_nxt = entry_i.value;
              end
            end
            default: ;
          endcase
          if (entry_i.op == OP_PROD) begin
            state_nxt = ST_MAG;
          end else if (entry_i.last) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MAG: begin
        // operand magnitudes and result sign
        ma_nxt    = acc_r[RESULT_W-1] ? (~acc_r + 1'b1) : acc_r;
        mb_nxt    = val_r[VALUE_W-1] ? (~val_r + 1'b1) : val_r;
        neg_nxt   = acc_r[RESULT_W-1] ^ val_r[VALUE_W-1];
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        plo_nxt   = mul_p;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        phi_nxt   = mul_p;
        state_nxt = ST_MADD;
      end
      ST_MADD: begin
        wide_nxt  = {phi_r, {HALF_W{1'b0}}} + {{(WIDE_W-RESULT_W){1'b0}}, plo_r};
        state_nxt = ST_MSAT;
      end
      ST_MSAT: begin
        acc_nxt   = prod_sat;
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // close the row and pick the result for the mode
        empty_nxt = row_empty;
        rcnt_nxt  = cnt_r;
        case (mode_i)
          MODE_SUM, MODE_PROD: res_nxt = acc_r;
          MODE_MAX, MODE_MIN: begin
            res_nxt = row_empty ? '0
                    : {{(RESULT_W-VALUE_W){best_r[VALUE_W-1]}}, best_r};
          end
          MODE_COUNT: res_nxt = {{(RESULT_W-COUNT_W){1'b0}}, cnt_r};
          default:    res_nxt = '0;
        endcase
        acc_nxt  = start_value(mode_i);
        best_nxt = '0;
        cnt_nxt  = '0;
        if (mode_i == MODE_MEAN && !row_empty) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_cnt_nxt   = rcnt_r;
          out_empty_nxt = empty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // mode write drops any partial row
    if (cfg_i.clear) begin
      acc_nxt  = start_value(cfg_i.mode);
      best_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  // control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      best_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      best_r      <= best_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    neg_r       <= neg_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    wide_r      <= wide_nxt;
    res_r       <= res_nxt;
    empty_r     <= empty_nxt;
    rcnt_r      <= rcnt_nxt;
    out_res_r   <= out_res_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

`default_nettype wire

[design/masked_row_reduction_unit.sv]
// top level of the masked row reduction unit
`default_nettype none

// Reduces rows of signed Q16.16 elements to one result per row in the mode held in
// the mode register (sum, product, mean, max, min, count); masked elements are skipped
// and the transfer with tlast set closes the row and yields one result transfer.
// A front stage classifies each element and drops masked ones that do not close a
// row, a queue of QUEUE_DEPTH entries decouples it from the back end, and a result
// register lets the back end keep working while a result waits. The back end takes
// one element per cycle in sum, mean, max, min and count modes while no row closes;
// in product mode an element goes through the pop, the magnitude step, two passes
// through the shared 32x32 multiplier and the add and saturation steps before the next.
// Rows close in finish and emit steps; non-empty mean rows use the bit-serial divider.
// Mode writes clear the row state and are to be made only while no row is in flight.
module masked_row_reduction_unit #(
  parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mrr_pkg::VALUE_W-1:0]     in_tdata,   // sample_value
  input  wire logic                            in_tuser,   // is_masked
  input  wire logic                            in_tlast,   // row_last
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mrr_pkg::OUT_TDATA_W-1:0]      out_tdata,  // row_result, unmasked_count
  output logic                                 out_tuser,  // row_empty
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mrr_pkg::MODE_W-1:0]      cfg_data    // reduce_mode
);
  import mrr_pkg::*;

  mode_t     mode_r;
  logic      cfg_fire;
  cfg_ctl_t  cfg_ctl;
  q_stat_t   q_stat;
  logic      q_push;
  logic      q_pop;
  entry_t    q_in;
  entry_t    q_out;

  // mode register, always ready
  assign cfg_ready    = 1'b1;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign cfg_ctl.clear = cfg_fire;
  assign cfg_ctl.mode  = cfg_fire ? mode_t'(cfg_data) : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
    end else if (cfg_fire) begin
      mode_r <= mode_t'(cfg_data);
    end
  end

  mrr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode_i    (mode_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat_i  (q_stat),
    .push_o    (q_push),
    .entry_o   (q_in)
  );

  mrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .stat_o  (q_stat)
  );

  mrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_ctl),
    .mode_i     (mode_r),
    .q_stat_i   (q_stat),
    .entry_i    (q_out),
    .pop_o      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // empty flag agrees with the reported count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[RESULT_W+COUNT_W-1:RESULT_W] == '0)))
    else $error("row_empty disagrees with unmasked_count");

  // count never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[RESULT_W+COUNT_W-1:RESULT_W] <= COUNT_W'(COUNT_CAP)))
    else $error("unmasked_count above cap");

  // empty row in product mode reports 1.0
  a_empty_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && mode_r == MODE_PROD) |-> (out_tdata[RESULT_W-1:0] == ONE_Q))
    else $error("empty product row not 1.0");

  // empty row in any other mode reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && mode_r != MODE_PROD) |-> (out_tdata[RESULT_W-1:0] == '0))
    else $error("empty row result not zero");

  // the queue is never popped while empty
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.has_data)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

[sim/mrr_row_checker.sv]
`timescale 1ns / 1ps
// row checker for the masked row reduction unit: predicts each row result and compares it
module mrr_row_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [mrr_pkg::VALUE_W-1:0]     in_tdata,   // sample_value
  input  wire logic                            in_tuser,   // is_masked
  input  wire logic                            in_tlast,   // row_last
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [mrr_pkg::OUT_TDATA_W-1:0] out_tdata,  // row_result, unmasked_count
  input  wire logic                            out_tuser,  // row_empty
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [mrr_pkg::MODE_W-1:0]      cfg_data,   // reduce_mode
  output int                                   fail_count,
  output int                                   outstanding,
  output int                                   rows_checked
);
  import mrr_pkg::*;

  // one predicted row result
  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic                       empty;
    logic [COUNT_W-1:0]         count;
  } row_outcome_t;

  // predicted copy of the block state
  logic [MODE_W-1:0]          red_mode;
  logic signed [RESULT_W-1:0] running_acc;
  logic signed [VALUE_W-1:0]  best_seen;
  logic [COUNT_W-1:0]         unmasked_seen;

  row_outcome_t expected_rows[$];
  int           mismatches;
  int           checked;

  // sum with saturation to the 64-bit range
  function automatic logic signed [RESULT_W-1:0] sat_sum(input logic signed [RESULT_W-1:0] a,
                                                         input logic signed [VALUE_W-1:0] v);
    logic signed [RESULT_W:0] s;
    s = a + v;
    if (s[RESULT_W] != s[RESULT_W-1]) return s[RESULT_W] ? RES_MIN : RES_MAX;
    return s[RESULT_W-1:0];
  endfunction

  // q16.16 product, truncated toward zero, then saturated
  function automatic logic signed [RESULT_W-1:0] sat_qmul(input logic signed [RESULT_W-1:0] a,
                                                          input logic signed [VALUE_W-1:0] v);
    logic signed [95:0] p;
    logic signed [95:0] q;
    p = a * v;
    if (p < 0) q = (p + ((96'sd1 <<< FRAC_BITS) - 96'sd1)) >>> FRAC_BITS;
    else q = p >>> FRAC_BITS;
    if (|q[95:RESULT_W-1] && !(&q[95:RESULT_W-1])) return q[95] ? RES_MIN : RES_MAX;
    return q[RESULT_W-1:0];
  endfunction

  // row state back to the start value of the current mode
  task automatic restart_row;
    running_acc   = (red_mode == MODE_PROD) ? ONE_Q : '0;
    best_seen     = '0;
    unmasked_seen = '0;
  endtask

  // fold one element into the row and queue the row result on the closing element
  task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input logic masked,
                                input logic last);
    row_outcome_t r;
    logic signed [RESULT_W-1:0] divisor;
    if (!masked) begin
      case (red_mode)
        MODE_SUM, MODE_MEAN: running_acc = sat_sum(running_acc, v);
        MODE_PROD:           running_acc = sat_qmul(running_acc, v);
        MODE_MAX:            if (unmasked_seen == 0 || v > best_seen) best_seen = v;
        MODE_MIN:            if (unmasked_seen == 0 || v < best_seen) best_seen = v;
        default: ;
      endcase
      if (unmasked_seen < COUNT_CAP) unmasked_seen = unmasked_seen + 1'b1;
    end
    if (last) begin
      r.empty = (unmasked_seen == 0);
      r.count = unmasked_seen;
      r.value = '0;
      divisor = RESULT_W'(unmasked_seen);
      // empty rows keep the zero result in mean, max and min
      case (red_mode)
        MODE_SUM, MODE_PROD: r.value = running_acc;
        MODE_MEAN:           if (!r.empty) r.value = running_acc / divisor;
        MODE_MAX, MODE_MIN:  if (!r.empty) r.value = RESULT_W'(best_seen);
        MODE_COUNT:          r.value = RESULT_W'(unmasked_seen);
        default:             r.value = '0;
      endcase
      expected_rows.insert(expected_rows.size(), r);
      restart_row();
    end
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result;
    row_outcome_t exp_row;
    logic signed [RESULT_W-1:0] got_value;
    logic [COUNT_W-1:0]         got_count;
    got_value = out_tdata[RESULT_W-1:0];
    got_count = out_tdata[RESULT_W +: COUNT_W];
    if (expected_rows.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result value=%0d empty=%0b count=%0d",
                 $realtime, got_value, out_tuser, got_count);
      mismatches++;
    end else begin
      exp_row = expected_rows.pop_front();
      checked++;
      if (got_value !== exp_row.value || out_tuser !== exp_row.empty ||
          got_count !== exp_row.count) begin
        if (mismatches < 10)
          $display("%0t: row mismatch exp %0d/%0b/%0d got %0d/%0b/%0d",
                   $realtime, exp_row.value, exp_row.empty, exp_row.count,
                   got_value, out_tuser, got_count);
        mismatches++;
      end
    end
  endtask

  // watch the three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      red_mode = MODE_SUM;
      restart_row();
      expected_rows.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        red_mode = cfg_data;
        restart_row();
      end
      if (in_tvalid && in_tready) absorb_element(in_tdata, in_tuser, in_tlast);
    end
    fail_count   <= mismatches;
    outstanding  <= expected_rows.size();
    rows_checked <= checked;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// top of the masked row reduction testbench: clock, reset, stimulus and verdict
module testbench;
  import mrr_pkg::*;

  // spare mode codes with no defined reduction
  localparam logic [MODE_W-1:0]  MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0]  MODE_SPARE_7 = 3'd7;
  localparam logic [VALUE_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN      = 32'h8000_0000;
  localparam int                 DRAIN_CYCLES = 150;
  localparam int                 CYCLE_LIMIT  = 1_000_000;
  localparam int                 PHASE_ITEMS  = 36;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [VALUE_W-1:0]     in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [MODE_W-1:0]      cfg_data   = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_ready;

  int fail_count;
  int outstanding;
  int rows_checked;
  int in_idle_pct   = 18;
  int out_idle_pct  = 78;
  int elements_sent = 0;
  int cycle_count   = 0;

  masked_row_reduction_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mrr_row_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .rows_checked(rows_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // random values, with extremes, small values and values near 1.0
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] mag;
    mag = '0;
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: begin
        mag = $urandom_range(32'hFFFF);
        return $urandom_range(1) ? -mag : mag;
      end
      4, 5: begin
        mag = $urandom_range(32'h3_0000, 32'h8000);
        return $urandom_range(1) ? -mag : mag;
      end
      default: return $urandom();
    endcase
  endfunction

  // one element transfer, with random idle cycles ahead of it
  task automatic send_element(input logic [VALUE_W-1:0] value, input logic masked,
                              input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= masked;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    elements_sent++;
  endtask

  // well-formed row of random length and content
  task automatic send_random_row;
    int len;
    bit all_masked;
    len        = ($urandom_range(15) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    all_masked = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++)
      send_element(pick_value(), all_masked || ($urandom_range(3) == 0), i == len - 1);
  endtask

  // wait until every row result is back and the block has gone quiet
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mode register write
  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // fixed rows: extremes, masked element, mean rounding toward zero, empty row
  task automatic send_directed_rows(input logic [MODE_W-1:0] m);
    send_element(VAL_MAX, 1'b0, 1'b0);
    send_element(VAL_MIN, 1'b1, 1'b0);
    send_element(VAL_MIN, 1'b0, 1'b1);
    // only a masked closing element
    send_element($urandom(), 1'b1, 1'b1);
    // product overflow into negative saturation
    if (m == MODE_PROD) begin
      send_element(VAL_MAX, 1'b0, 1'b0);
      send_element(VAL_MAX, 1'b0, 1'b0);
      send_element(VAL_MAX, 1'b0, 1'b0);
      send_element(VAL_MIN, 1'b0, 1'b1);
    end
  endtask

  // one mode setting: write, optional fixed rows, then random rows
  task automatic run_mode_phase(input logic [MODE_W-1:0] m, input int n, input bit directed);
    int start;
    wait_drained();
    write_mode(m);
    if (directed) send_directed_rows(m);
    start = elements_sent;
    while (elements_sent - start < n) send_random_row();
  endtask

  // stimulus sequence and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    in_idle_pct  = 18;
    out_idle_pct = 78;
    for (int m = 0; m <= 5; m++) run_mode_phase(MODE_W'(m), PHASE_ITEMS, 1'b1);

    // the other way round, spare modes included
    in_idle_pct  = 78;
    out_idle_pct = 18;
    run_mode_phase(MODE_SPARE_6, 15, 1'b0);
    run_mode_phase(MODE_SPARE_7, 15, 1'b0);
    for (int m = 5; m >= 0; m--) run_mode_phase(MODE_W'(m), PHASE_ITEMS, 1'b0);

    // no idling at all
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int m = 0; m <= 5; m++) run_mode_phase(MODE_W'(m), PHASE_ITEMS, 1'b0);

    wait_drained();

    $display("covered %0d elements and %0d row results in all modes incl. spare codes,",
             elements_sent, rows_checked);
    $display("under three idle profiles with extreme values and empty rows");
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
